@@ hw/rtl/cv2d_pkg.sv @@
package cv2d_pkg;

  localparam int OP_W     = 2;
  localparam int POS_W    = 6;
  localparam int VALUE_W  = 16;
  localparam int SUM_W    = 40;
  localparam int PROD_W   = 2 * VALUE_W;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 6;

  localparam int IMG_SIZE_W  = 6;
  localparam int KER_SIZE_W  = 4;
  localparam int STEP_SIZE_W = 4;

  localparam logic [OP_W-1:0] OP_PIXEL = 2'd0;
  localparam logic [OP_W-1:0] OP_COEFF = 2'd1;
  localparam logic [OP_W-1:0] OP_QUERY = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_SIZE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_KERNEL_SIZE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_STEP_SIZE   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_FULL_MODE   = 2'd3;

  typedef logic [OP_W-1:0]           op_t;
  typedef logic [POS_W-1:0]          pos_t;
  typedef logic signed [VALUE_W-1:0] value_t;
  typedef logic signed [PROD_W-1:0]  prod_t;
  typedef logic signed [SUM_W-1:0]   sum_t;

endpackage

@@ hw/rtl/cv2d_if.sv @@
interface cv2d_in_if;
  logic              valid;
  logic              ready;
  cv2d_pkg::op_t     op;
  cv2d_pkg::pos_t    row;
  cv2d_pkg::pos_t    col;
  cv2d_pkg::value_t  value;

  modport source (output valid, output op, output row, output col, output value, input ready);
  modport sink   (input valid, input op, input row, input col, input value, output ready);
endinterface

interface cv2d_out_if;
  logic              valid;
  logic              ready;
  cv2d_pkg::sum_t    sum;
  cv2d_pkg::pos_t    out_row;
  cv2d_pkg::pos_t    out_col;
  logic              bad_position;

  modport source (output valid, output sum, output out_row, output out_col,
                  output bad_position, input ready);
  modport sink   (input valid, input sum, input out_row, input out_col,
                  input bad_position, output ready);
endinterface

@@ hw/rtl/conv2d_valid_and_full.sv @@
// write request: accepted while idle, one per cycle while no query is in progress
// query request: result after the tap walk and the MAC pipeline drain, one tap read and one
//   multiply-accumulate per cycle; the next request is taken once the result is loaded
//   (bad position: result without a tap walk); a held result stalls it
// reset (synchronous, active low): control, output valid and config registers cleared
//   to N=32, K=3, S=1, valid mode; image and coeff memories hold no reset value
module conv2d_valid_and_full #(
  parameter int MAX_IMAGE   = 32,
  parameter int MAX_KERNEL  = 8,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [cv2d_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [cv2d_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  cv2d_in_if.sink                             in_req,
  cv2d_out_if.source                          out_res
);

  localparam int KEEP    = (SAMPLE_BITS < cv2d_pkg::VALUE_W) ? SAMPLE_BITS : cv2d_pkg::VALUE_W;
  localparam int IMG_D   = MAX_IMAGE * MAX_IMAGE;
  localparam int IMG_AW  = $clog2(IMG_D);
  localparam int IX_W    = $clog2(MAX_IMAGE);
  localparam int KER_D   = MAX_KERNEL * MAX_KERNEL;
  localparam int KER_AW  = (KER_D > 1) ? $clog2(KER_D) : 1;
  localparam int CRD_W   = 12;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_WALK  = 2'd1;
  localparam logic [1:0] ST_DRAIN = 2'd2;
  localparam logic [1:0] ST_DONE  = 2'd3;

  // configuration registers
  logic [cv2d_pkg::IMG_SIZE_W-1:0]  image_size_r;
  logic [cv2d_pkg::KER_SIZE_W-1:0]  kernel_size_r;
  logic [cv2d_pkg::STEP_SIZE_W-1:0] step_size_r;
  logic                             full_mode_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      image_size_r  <= 6'd32;
      kernel_size_r <= 4'd3;
      step_size_r   <= 4'd1;
      full_mode_r   <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        cv2d_pkg::CFG_IMAGE_SIZE:  image_size_r  <= cfg_wdata[cv2d_pkg::IMG_SIZE_W-1:0];
        cv2d_pkg::CFG_KERNEL_SIZE: kernel_size_r <= cfg_wdata[cv2d_pkg::KER_SIZE_W-1:0];
        cv2d_pkg::CFG_STEP_SIZE:   step_size_r   <= cfg_wdata[cv2d_pkg::STEP_SIZE_W-1:0];
        cv2d_pkg::CFG_FULL_MODE:   full_mode_r   <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // effective sizes
  logic [cv2d_pkg::IMG_SIZE_W-1:0]  n_eff;
  logic [cv2d_pkg::KER_SIZE_W-1:0]  k_eff;
  logic [cv2d_pkg::STEP_SIZE_W-1:0] s_eff;

  always_comb begin
    if (image_size_r == '0)
      n_eff = 6'd1;
    else if (int'(image_size_r) > MAX_IMAGE)
      n_eff = 6'(MAX_IMAGE);
    else
      n_eff = image_size_r;
    if (kernel_size_r == '0)
      k_eff = 4'd1;
    else if (int'(kernel_size_r) > MAX_KERNEL)
      k_eff = 4'(MAX_KERNEL);
    else
      k_eff = kernel_size_r;
    s_eff = (step_size_r == '0) ? 4'd1 : step_size_r;
  end

  // control
  logic [1:0]                      state_r, state_nxt;
  logic [cv2d_pkg::KER_SIZE_W-1:0] i_r, j_r;
  logic [CRD_W-1:0]                x_r, y_r, c0_r;
  cv2d_pkg::pos_t                  qrow_r, qcol_r;
  logic                            qbad_r;
  logic                            v1_r, v2_r;
  cv2d_pkg::sum_t                  acc_r;
  cv2d_pkg::prod_t                 prod_r;

  logic in_fire, out_fire, is_query, is_pix, is_coef;
  assign in_req.ready = (state_r == ST_IDLE);
  assign in_fire  = in_req.valid && in_req.ready;
  assign out_fire = out_res.valid && out_res.ready;
  assign is_query = in_fire && (in_req.op == cv2d_pkg::OP_QUERY);
  assign is_pix   = in_fire && (in_req.op == cv2d_pkg::OP_PIXEL)
                    && (int'(in_req.row) < MAX_IMAGE) && (int'(in_req.col) < MAX_IMAGE);
  assign is_coef  = in_fire && (in_req.op == cv2d_pkg::OP_COEFF)
                    && (int'(in_req.row) < MAX_KERNEL) && (int'(in_req.col) < MAX_KERNEL);

  // position check and window origin
  logic [9:0]       row_s, col_s;
  logic [6:0]       full_lim;
  logic [5:0]       n_minus_k;
  logic             q_bad;
  logic [CRD_W-1:0] r0, c0;

  always_comb begin
    row_s     = 10'(in_req.row) * 10'(s_eff);
    col_s     = 10'(in_req.col) * 10'(s_eff);
    full_lim  = 7'(n_eff) + 7'(k_eff) - 7'd1;
    n_minus_k = n_eff - 6'(k_eff);
    if (full_mode_r) begin
      q_bad = (7'(in_req.row) >= full_lim) || (7'(in_req.col) >= full_lim);
      r0    = CRD_W'(in_req.row) - CRD_W'(k_eff) + CRD_W'(1);
      c0    = CRD_W'(in_req.col) - CRD_W'(k_eff) + CRD_W'(1);
    end else begin
      q_bad = (6'(k_eff) > n_eff) || (row_s > 10'(n_minus_k)) || (col_s > 10'(n_minus_k));
      r0    = CRD_W'(row_s);
      c0    = CRD_W'(col_s);
    end
  end

  // tap walk
  logic last_tap, x_ok, y_ok, tap_ok;
  assign last_tap = (i_r == k_eff - 4'd1) && (j_r == k_eff - 4'd1);
  assign x_ok     = !x_r[CRD_W-1] && (x_r < CRD_W'(n_eff));
  assign y_ok     = !y_r[CRD_W-1] && (y_r < CRD_W'(n_eff));
  assign tap_ok   = (state_r == ST_WALK) && x_ok && y_ok;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:  if (is_query) state_nxt = q_bad ? ST_DONE : ST_WALK;
      ST_WALK:  if (last_tap) state_nxt = ST_DRAIN;
      ST_DRAIN: if (!v1_r && !v2_r) state_nxt = ST_DONE;
      ST_DONE:  if (!out_res.valid || out_res.ready) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      v1_r    <= 1'b0;
      v2_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      v1_r    <= tap_ok;
      v2_r    <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (is_query) begin
      i_r    <= '0;
      j_r    <= '0;
      x_r    <= r0;
      y_r    <= c0;
      c0_r   <= c0;
      qrow_r <= in_req.row;
      qcol_r <= in_req.col;
      qbad_r <= q_bad;
      acc_r  <= '0;
    end else begin
      if (state_r == ST_WALK) begin
        if (j_r == k_eff - 4'd1) begin
          j_r <= '0;
          y_r <= c0_r;
          i_r <= i_r + 4'd1;
          x_r <= x_r + CRD_W'(1);
        end else begin
          j_r <= j_r + 4'd1;
          y_r <= y_r + CRD_W'(1);
        end
      end
      if (v2_r)
        acc_r <= acc_r + cv2d_pkg::SUM_W'(prod_r);
    end
  end

  // stores
  logic [KEEP-1:0]   img_mem [IMG_D];
  logic [KEEP-1:0]   ker_mem [KER_D];
  logic [KEEP-1:0]   img_q, ker_q;
  logic [IMG_AW-1:0] img_wa, img_ra;
  logic [KER_AW-1:0] ker_wa, ker_ra;

  assign img_wa = IMG_AW'(int'(in_req.row) * MAX_IMAGE + int'(in_req.col));
  assign ker_wa = KER_AW'(int'(in_req.row) * MAX_KERNEL + int'(in_req.col));
  assign img_ra = tap_ok ? IMG_AW'(int'(x_r[IX_W-1:0]) * MAX_IMAGE + int'(y_r[IX_W-1:0])) : '0;
  assign ker_ra = KER_AW'(int'(i_r) * MAX_KERNEL + int'(j_r));

  always_ff @(posedge clk) begin
    if (is_pix)
      img_mem[img_wa] <= in_req.value[KEEP-1:0];
    img_q <= img_mem[img_ra];
  end

  always_ff @(posedge clk) begin
    if (is_coef)
      ker_mem[ker_wa] <= in_req.value[KEEP-1:0];
    ker_q <= ker_mem[ker_ra];
  end

  cv2d_pkg::value_t img_s, ker_s;
  assign img_s = cv2d_pkg::VALUE_W'($signed(img_q));
  assign ker_s = cv2d_pkg::VALUE_W'($signed(ker_q));

  always_ff @(posedge clk) begin
    prod_r <= img_s * ker_s;
  end

  // output register
  logic           out_valid_r, out_valid_nxt;
  cv2d_pkg::sum_t sum_r;
  cv2d_pkg::pos_t orow_r, ocol_r;
  logic           bad_r;
  logic           load_out;

  assign load_out = (state_r == ST_DONE) && (!out_valid_r || out_res.ready);

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (load_out)
      out_valid_nxt = 1'b1;
    else if (out_fire)
      out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n)
      out_valid_r <= 1'b0;
    else
      out_valid_r <= out_valid_nxt;
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      sum_r  <= qbad_r ? '0 : acc_r;
      orow_r <= qrow_r;
      ocol_r <= qcol_r;
      bad_r  <= qbad_r;
    end
  end

  assign out_res.valid        = out_valid_r;
  assign out_res.sum          = sum_r;
  assign out_res.out_row      = orow_r;
  assign out_res.out_col      = ocol_r;
  assign out_res.bad_position = bad_r;

  a_pipe_empty_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> (!v1_r && !v2_r))
    else $error("mac pipeline busy while idle");

  a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && bad_r) |-> (sum_r == '0))
    else $error("bad position with nonzero sum");

  a_tap_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_WALK) |-> ((i_r < k_eff) && (j_r < k_eff)))
    else $error("tap counter outside kernel");

  a_query_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    is_query |=> (state_r != ST_IDLE))
    else $error("query request not started");

endmodule

@@ tb/tb_top.sv @@
localparam int IMG_SIDE = 32;
localparam int TAP_SIDE = 8;
localparam cv2d_pkg::op_t OP_UNUSED = 2'd3;

typedef struct packed {
  cv2d_pkg::sum_t sum;
  cv2d_pkg::pos_t row;
  cv2d_pkg::pos_t col;
  logic bad;
} conv_result_t;

class conv_scoreboard;
  cv2d_pkg::value_t pixels [IMG_SIDE*IMG_SIDE];
  cv2d_pkg::value_t taps [TAP_SIDE*TAP_SIDE];
  bit pixel_set [IMG_SIDE*IMG_SIDE];
  bit tap_set [TAP_SIDE*TAP_SIDE];
  int side_reg;
  int ksize_reg;
  int stride_reg;
  bit full_reg;
  conv_result_t sums_due [$];
  int mismatches;
  int sums_seen;
  int bad_seen;

  function new();
    side_reg = 32;
    ksize_reg = 3;
    stride_reg = 1;
    full_reg = 1'b0;
    mismatches = 0;
    sums_seen = 0;
    bad_seen = 0;
  endfunction

  function void write_reg(logic [cv2d_pkg::CFG_IDX_W-1:0] idx,
                          logic [cv2d_pkg::CFG_DATA_W-1:0] data);
    case (idx)
      cv2d_pkg::CFG_IMAGE_SIZE:  side_reg = int'(data);
      cv2d_pkg::CFG_KERNEL_SIZE: ksize_reg = int'(data[cv2d_pkg::KER_SIZE_W-1:0]);
      cv2d_pkg::CFG_STEP_SIZE:   stride_reg = int'(data[cv2d_pkg::STEP_SIZE_W-1:0]);
      cv2d_pkg::CFG_FULL_MODE:   full_reg = data[0];
      default: ;
    endcase
  endfunction

  // effective sizes, output side and window corner for one output position
  function void window(input int r, input int c, output int n, output int k,
                       output int span, output int r0, output int c0);
    int s;
    n = (side_reg == 0) ? 1 : (side_reg > IMG_SIDE) ? IMG_SIDE : side_reg;
    k = (ksize_reg == 0) ? 1 : (ksize_reg > TAP_SIDE) ? TAP_SIDE : ksize_reg;
    s = (stride_reg == 0) ? 1 : stride_reg;
    if (full_reg) begin
      span = n + k - 1;
      r0 = r - (k - 1);
      c0 = c - (k - 1);
    end else begin
      span = (k > n) ? 0 : (n - k) / s + 1;
      r0 = r * s;
      c0 = c * s;
    end
  endfunction

  function void note_request(cv2d_pkg::op_t op, cv2d_pkg::pos_t row, cv2d_pkg::pos_t col,
                             cv2d_pkg::value_t value);
    int n, k, span, r0, c0, x, y;
    conv_result_t res;
    case (op)
      cv2d_pkg::OP_PIXEL: begin
        if (row < IMG_SIDE && col < IMG_SIDE) begin
          pixels[row*IMG_SIDE+col] = value;
          pixel_set[row*IMG_SIDE+col] = 1'b1;
        end
      end
      cv2d_pkg::OP_COEFF: begin
        if (row < TAP_SIDE && col < TAP_SIDE) begin
          taps[row*TAP_SIDE+col] = value;
          tap_set[row*TAP_SIDE+col] = 1'b1;
        end
      end
      cv2d_pkg::OP_QUERY: begin
        window(int'(row), int'(col), n, k, span, r0, c0);
        res.row = row;
        res.col = col;
        res.sum = '0;
        res.bad = (int'(row) >= span || int'(col) >= span);
        if (!res.bad) begin
          for (int i = 0; i < k; i++) begin
            x = r0 + i;
            if (x >= 0 && x < n) begin
              for (int j = 0; j < k; j++) begin
                y = c0 + j;
                if (y >= 0 && y < n)
                  res.sum = res.sum + cv2d_pkg::sum_t'(pixels[x*IMG_SIDE+y])
                                    * cv2d_pkg::sum_t'(taps[i*TAP_SIDE+j]);
              end
            end
          end
        end
        sums_due.push_back(res);
      end
      default: ;
    endcase
  endfunction

  function void check_result(conv_result_t got);
    conv_result_t want;
    sums_seen++;
    if (got.bad)
      bad_seen++;
    if (sums_due.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("result with no query pending: sum=%0d row=%0d col=%0d bad=%0b",
                 $signed(got.sum), got.row, got.col, got.bad);
      return;
    end
    want = sums_due.pop_front();
    if (got.sum !== want.sum || got.row !== want.row || got.col !== want.col ||
        got.bad !== want.bad) begin
      mismatches++;
      if (mismatches <= 10)
        $display({"result mismatch: expected sum=%0d row=%0d col=%0d bad=%0b,",
                  " got sum=%0d row=%0d col=%0d bad=%0b"},
                 $signed(want.sum), want.row, want.col, want.bad,
                 $signed(got.sum), got.row, got.col, got.bad);
    end
  endfunction
endclass

module tb_top;
  localparam int IDLE_TAIL = TAP_SIDE * TAP_SIDE + 8;
  localparam int STUCK_LIMIT = 4000;
  localparam int PHASE_ITEMS = 70;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [cv2d_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [cv2d_pkg::CFG_DATA_W-1:0] cfg_wdata;

  cv2d_in_if in_bus ();
  cv2d_out_if res_bus ();

  conv2d_valid_and_full u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_req    (in_bus.sink),
    .out_res   (res_bus.source)
  );

  conv_scoreboard book;
  conv_result_t seen_res;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int stuck_cycles = 0;
  int requests_sent = 0;
  int settings_used = 0;

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  always @(negedge clk) begin
    res_bus.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    if (rst_n && res_bus.valid && res_bus.ready) begin
      seen_res.sum = res_bus.sum;
      seen_res.row = res_bus.out_row;
      seen_res.col = res_bus.out_col;
      seen_res.bad = res_bus.bad_position;
      book.check_result(seen_res);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_bus.valid && in_bus.ready) || (res_bus.valid && res_bus.ready)) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles >= STUCK_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  function automatic cv2d_pkg::value_t any_value();
    case ($urandom_range(9))
      0: return 16'sh8000;
      1: return 16'sh7fff;
      2: return '0;
      default: return cv2d_pkg::value_t'($urandom);
    endcase
  endfunction

  // mostly inside the store, sometimes beyond it
  function automatic cv2d_pkg::pos_t any_pos(int lim);
    if ($urandom_range(99) < 85)
      return cv2d_pkg::pos_t'($urandom_range(lim - 1));
    return cv2d_pkg::pos_t'($urandom_range(38, lim));
  endfunction

  task automatic send_req(cv2d_pkg::op_t op, cv2d_pkg::pos_t row, cv2d_pkg::pos_t col,
                          cv2d_pkg::value_t value);
    while ($urandom_range(99) < send_idle_pct)
      @(negedge clk);
    in_bus.valid = 1'b1;
    in_bus.op = op;
    in_bus.row = row;
    in_bus.col = col;
    in_bus.value = value;
    @(posedge clk);
    while (!in_bus.ready)
      @(posedge clk);
    book.note_request(op, row, col, value);
    requests_sent++;
    @(negedge clk);
    in_bus.valid = 1'b0;
  endtask

  // load whatever the window of a valid position still lacks, then ask for the sum
  task automatic query_at(cv2d_pkg::pos_t row, cv2d_pkg::pos_t col);
    int n, k, span, r0, c0;
    book.window(int'(row), int'(col), n, k, span, r0, c0);
    if (int'(row) < span && int'(col) < span) begin
      for (int i = 0; i < k; i++) begin
        for (int j = 0; j < k; j++) begin
          if (r0 + i >= 0 && r0 + i < n && c0 + j >= 0 && c0 + j < n) begin
            if (!book.pixel_set[(r0+i)*IMG_SIDE+c0+j])
              send_req(cv2d_pkg::OP_PIXEL, cv2d_pkg::pos_t'(r0 + i), cv2d_pkg::pos_t'(c0 + j),
                       any_value());
            if (!book.tap_set[i*TAP_SIDE+j])
              send_req(cv2d_pkg::OP_COEFF, cv2d_pkg::pos_t'(i), cv2d_pkg::pos_t'(j),
                       any_value());
          end
        end
      end
    end
    send_req(cv2d_pkg::OP_QUERY, row, col, cv2d_pkg::value_t'($urandom));
  endtask

  task automatic drain_results();
    while (book.sums_due.size() != 0)
      @(negedge clk);
    repeat (IDLE_TAIL) @(negedge clk);
  endtask

  task automatic write_cfg(logic [cv2d_pkg::CFG_IDX_W-1:0] idx,
                           logic [cv2d_pkg::CFG_DATA_W-1:0] data);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_wdata = data;
    @(posedge clk);
    book.write_reg(idx, data);
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic configure(logic [cv2d_pkg::CFG_DATA_W-1:0] n,
                           logic [cv2d_pkg::CFG_DATA_W-1:0] k,
                           logic [cv2d_pkg::CFG_DATA_W-1:0] s,
                           logic [cv2d_pkg::CFG_DATA_W-1:0] f);
    drain_results();
    write_cfg(cv2d_pkg::CFG_IMAGE_SIZE, n);
    write_cfg(cv2d_pkg::CFG_KERNEL_SIZE, k);
    write_cfg(cv2d_pkg::CFG_STEP_SIZE, s);
    write_cfg(cv2d_pkg::CFG_FULL_MODE, f);
    settings_used++;
  endtask

  task automatic random_request();
    int n, k, span, r0, c0, pick;
    pick = $urandom_range(99);
    book.window(0, 0, n, k, span, r0, c0);
    if (pick < 55 && span > 0)
      query_at(cv2d_pkg::pos_t'($urandom_range(span - 1)),
               cv2d_pkg::pos_t'($urandom_range(span - 1)));
    else if (pick < 65)
      query_at(cv2d_pkg::pos_t'($urandom_range(38)), cv2d_pkg::pos_t'($urandom_range(38)));
    else if (pick < 85)
      send_req(cv2d_pkg::OP_PIXEL, any_pos(IMG_SIDE), any_pos(IMG_SIDE), any_value());
    else if (pick < 95)
      send_req(cv2d_pkg::OP_COEFF, any_pos(TAP_SIDE), any_pos(TAP_SIDE), any_value());
    else
      send_req(OP_UNUSED, cv2d_pkg::pos_t'($urandom_range(38)),
               cv2d_pkg::pos_t'($urandom_range(38)), cv2d_pkg::value_t'($urandom));
  endtask

  initial begin
    logic [cv2d_pkg::CFG_DATA_W-1:0] plan [10][4];
    int first;
    bit paused;
    plan = '{'{6'd32, 6'd3, 6'd1, 6'd0}, '{6'd32, 6'd8, 6'd8, 6'd0},
             '{6'd1, 6'd1, 6'd1, 6'd1}, '{6'd32, 6'd8, 6'd1, 6'd1},
             '{6'd5, 6'd2, 6'd3, 6'd0}, '{6'd0, 6'd0, 6'd0, 6'd0},
             '{6'd63, 6'd15, 6'd5, 6'd0}, '{6'd4, 6'd6, 6'd2, 6'd0},
             '{6'd7, 6'd19, 6'd0, 6'd1}, '{6'd0, 6'd0, 6'd0, 6'd0}};
    book = new();
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    in_bus.valid = 1'b0;
    in_bus.op = cv2d_pkg::OP_PIXEL;
    in_bus.row = '0;
    in_bus.col = '0;
    in_bus.value = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // reset settings, value extremes, stray writes, unknown op, bad positions
    send_req(cv2d_pkg::OP_PIXEL, 6'd0, 6'd0, 16'sh7fff);
    send_req(cv2d_pkg::OP_PIXEL, 6'd0, 6'd1, 16'sh8000);
    send_req(cv2d_pkg::OP_COEFF, 6'd0, 6'd0, 16'sh8000);
    send_req(cv2d_pkg::OP_COEFF, 6'd0, 6'd1, 16'sh8000);
    query_at(6'd0, 6'd0);
    send_req(cv2d_pkg::OP_PIXEL, 6'd38, 6'd5, 16'sh1234);
    send_req(cv2d_pkg::OP_PIXEL, 6'd5, 6'd33, 16'sh4321);
    send_req(cv2d_pkg::OP_COEFF, 6'd8, 6'd0, 16'sh7fff);
    send_req(OP_UNUSED, 6'd17, 6'd21, 16'sh5a5a);
    query_at(6'd30, 6'd0);
    query_at(6'd0, 6'd38);

    for (int ph = 0; ph < 10; ph++) begin
      if (ph == 9) begin
        plan[ph][0] = cv2d_pkg::CFG_DATA_W'($urandom);
        plan[ph][1] = cv2d_pkg::CFG_DATA_W'($urandom);
        plan[ph][2] = cv2d_pkg::CFG_DATA_W'($urandom);
        plan[ph][3] = cv2d_pkg::CFG_DATA_W'($urandom);
      end
      configure(plan[ph][0], plan[ph][1], plan[ph][2], plan[ph][3]);
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 58; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 58; end
        default: begin send_idle_pct = 27; recv_stall_pct = 27; end
      endcase
      first = requests_sent;
      paused = 1'b0;
      while (requests_sent - first < PHASE_ITEMS) begin
        if (!paused && requests_sent - first >= PHASE_ITEMS / 2) begin
          drain_results();
          paused = 1'b1;
        end
        random_request();
      end
    end

    drain_results();
    $display("%0d requests over %0d register settings plus reset values", requests_sent,
             settings_used);
    $display("%0d window sums checked, %0d of them out-of-range positions, %0d mismatches",
             book.sums_seen, book.bad_seen, book.mismatches);
    if (book.mismatches == 0 && book.sums_due.size() == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end
endmodule
